// ===== rtl/pls_pkg.sv =====
// pls_pkg: operation codes, status codes and the command/status structs
// shared by the positional list engine controller and datapath.
// No dependencies.
`default_nettype none

package pls_pkg;

  // Operation kinds carried by an input item
  localparam logic [3:0] KIND_INS_FIRST = 4'd0;
  localparam logic [3:0] KIND_INS_LAST  = 4'd1;
  localparam logic [3:0] KIND_INS_AT    = 4'd2;
  localparam logic [3:0] KIND_DEL_FIRST = 4'd3;
  localparam logic [3:0] KIND_DEL_LAST  = 4'd4;
  localparam logic [3:0] KIND_DEL_AT    = 4'd5;
  localparam logic [3:0] KIND_SET       = 4'd6;
  localparam logic [3:0] KIND_SEARCH    = 4'd7;
  localparam logic [3:0] KIND_FREQ      = 4'd8;

  // Result status codes
  localparam logic [1:0] STS_OK      = 2'd0;
  localparam logic [1:0] STS_BAD_POS = 2'd1;
  localparam logic [1:0] STS_EMPTY   = 2'd2;
  localparam logic [1:0] STS_FULL    = 2'd3;

  // Operation classes reported to the controller
  localparam logic [2:0] OPC_NONE = 3'd0;
  localparam logic [2:0] OPC_INS  = 3'd1;
  localparam logic [2:0] OPC_DEL  = 3'd2;
  localparam logic [2:0] OPC_SET  = 3'd3;
  localparam logic [2:0] OPC_SCAN = 3'd4;

  // Pointer load sources
  localparam logic [1:0] PTR_ZERO   = 2'd0;
  localparam logic [1:0] PTR_COUNT  = 2'd1;
  localparam logic [1:0] PTR_DEL_AT = 2'd2;

  // Read address sources
  localparam logic [1:0] RD_PTR    = 2'd0;
  localparam logic [1:0] RD_PTR_M1 = 2'd1;
  localparam logic [1:0] RD_PTR_P1 = 2'd2;

  // Write address/data sources
  localparam logic [1:0] WR_SHIFT = 2'd0;  // mem[ptr]    <= read data
  localparam logic [1:0] WR_INS   = 2'd1;  // mem[ins_at] <= value
  localparam logic [1:0] WR_SET   = 2'd2;  // mem[pos-1]  <= value

  typedef struct packed {
    logic       latch;        // capture the accepted item
    logic       save_status;  // register result status, clear match count
    logic       load_ptr;
    logic [1:0] ptr_src;
    logic       ptr_inc;
    logic       ptr_dec;
    logic       rd_en;
    logic [1:0] rd_src;
    logic       scan_rd;      // this read feeds the comparator
    logic       wr_en;
    logic [1:0] wr_src;
    logic       cnt_inc;
    logic       cnt_dec;
    logic       load_out;
  } pls_cmd_t;

  typedef struct packed {
    logic [2:0] op_class;
    logic       err;           // rejected: no change to the list
    logic       empty;
    logic       ins_no_shift;  // insert lands at the current end
    logic       up_last;       // this shift-up write is the last one
    logic       del_no_shift;  // delete removes the last entry
    logic       dn_last;       // this shift-down write is the last one
    logic       scan_last;     // this scan read is the last one
  } pls_stat_t;

endpackage

`default_nettype wire

// ===== rtl/pls_if.sv =====
// pls_in_if / pls_out_if: valid/ready channels for operation items and
// result items of the positional list engine. No dependencies.
`default_nettype none

interface pls_in_if;
  logic               valid;
  logic               ready;
  logic        [3:0]  kind;
  logic signed [31:0] value;
  logic        [7:0]  position;

  modport source (output valid, kind, value, position, input ready);
  modport sink   (input valid, kind, value, position, output ready);
endinterface

interface pls_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic       found;
  logic [6:0] match_count;
  logic [6:0] entry_count;

  modport source (output valid, status, found, match_count, entry_count, input ready);
  modport sink   (input valid, status, found, match_count, entry_count, output ready);
endinterface

`default_nettype wire

// ===== rtl/positional_list_engine.sv =====
// Positional list engine: an ordered store of up to CAPACITY words kept in a
// single-port memory. Each item is one operation and gives one result item.
// A set writes one word; rejected and unknown operations touch no memory. An
// insert or delete moves each affected entry by a read and then a write, and a
// search or frequency count reads each entry held through the comparator
// (none when the list is empty). The next item is accepted as soon as the
// previous result sits in the output register. Reset clears the entry count,
// not the memory contents; no clearing pass.
// Depends on pls_pkg, pls_if, pls_ctrl and pls_datapath.
`default_nettype none

module positional_list_engine #(
  parameter int CAPACITY   = 64,
  parameter int DATA_WIDTH = 32
) (
  input  wire         clk,
  input  wire         rst_n,
  pls_in_if.sink      in_ch,
  pls_out_if.source   out_ch
);
  import pls_pkg::*;

  pls_cmd_t  cmd;
  pls_stat_t st;

  pls_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .st        (st),
    .cmd       (cmd)
  );

  pls_datapath #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .st              (st),
    .in_kind         (in_ch.kind),
    .in_value        (in_ch.value),
    .in_position     (in_ch.position),
    .out_status      (out_ch.status),
    .out_found       (out_ch.found),
    .out_match_count (out_ch.match_count),
    .out_entry_count (out_ch.entry_count)
  );

endmodule

`default_nettype wire

// ===== rtl/pls_datapath.sv =====
// pls_datapath: entry memory, entry count, scan pointer, comparator and
// result registers of the positional list engine. Uses pls_pkg.
`default_nettype none

module pls_datapath #(
  parameter int CAPACITY   = 64,
  parameter int DATA_WIDTH = 32
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  pls_pkg::pls_cmd_t    cmd,
  output pls_pkg::pls_stat_t   st,
  input  wire [3:0]            in_kind,
  input  wire signed [31:0]    in_value,
  input  wire [7:0]            in_position,
  output logic [1:0]           out_status,
  output logic                 out_found,
  output logic [6:0]           out_match_count,
  output logic [6:0]           out_entry_count
);
  import pls_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = (CW > 8) ? CW + 1 : 9;
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  logic [DATA_WIDTH-1:0] mem [CAPACITY];
  logic [DATA_WIDTH-1:0] rdata_r;

  logic [3:0]            kind_r;
  logic [DATA_WIDTH-1:0] value_r;
  logic [7:0]            pos_r;
  logic [CW-1:0]         count_r;
  logic [CW-1:0]         ptr_r;
  logic [CW-1:0]         match_r;
  logic                  cmp_pend_r;
  logic [1:0]            res_status_r;

  logic [DATA_WIDTH-1:0] value_fit;
  logic [PW-1:0]         pos_w;
  logic [PW-1:0]         cnt_w;
  logic [PW-1:0]         pos_m1;
  logic [CW-1:0]         pos_idx;
  logic                  ins_pos_ok;
  logic                  del_pos_ok;
  logic                  full;
  logic                  empty;
  logic [CW-1:0]         ins_at;
  logic [CW-1:0]         del_at;
  logic [1:0]            code;
  logic [2:0]            op_class;
  logic [CW-1:0]         rd_addr;
  logic [CW-1:0]         wr_addr;
  logic [DATA_WIDTH-1:0] wr_data;
  logic [CW+6:0]         match_ext;
  logic [CW+6:0]         count_ext;

  // Sign-extend or truncate the 32-bit word to the stored width
  if (DATA_WIDTH <= 32) begin : g_trunc
    assign value_fit = in_value[DATA_WIDTH-1:0];
  end else begin : g_sext
    assign value_fit = {{(DATA_WIDTH-32){in_value[31]}}, in_value};
  end

  // Position checks against the current count
  assign pos_w      = {{(PW-8){1'b0}}, pos_r};
  assign cnt_w      = {{(PW-CW){1'b0}}, count_r};
  assign pos_m1     = pos_w - PW'(1);
  assign pos_idx    = pos_m1[CW-1:0];
  assign ins_pos_ok = (pos_r != 8'd0) && (pos_w <= cnt_w + PW'(1));
  assign del_pos_ok = (pos_r != 8'd0) && (pos_w <= cnt_w);
  assign full       = (count_r == CAP_C);
  assign empty      = (count_r == '0);

  // Target index of insert and delete
  always_comb begin
    unique case (kind_r)
      KIND_INS_FIRST: ins_at = '0;
      KIND_INS_LAST:  ins_at = count_r;
      default:        ins_at = pos_idx;
    endcase
    unique case (kind_r)
      KIND_DEL_FIRST: del_at = '0;
      KIND_DEL_LAST:  del_at = count_r - CW'(1);
      default:        del_at = pos_idx;
    endcase
  end

  // Decode: operation class and result status
  always_comb begin
    op_class = OPC_NONE;
    code     = STS_OK;
    unique case (kind_r)
      KIND_INS_FIRST, KIND_INS_LAST, KIND_INS_AT: begin
        op_class = OPC_INS;
        if (full)                                   code = STS_FULL;
        else if (kind_r == KIND_INS_AT && !ins_pos_ok) code = STS_BAD_POS;
      end
      KIND_DEL_FIRST, KIND_DEL_LAST, KIND_DEL_AT: begin
        op_class = OPC_DEL;
        if (empty)                                  code = STS_EMPTY;
        else if (kind_r == KIND_DEL_AT && !del_pos_ok) code = STS_BAD_POS;
      end
      KIND_SET: begin
        op_class = OPC_SET;
        if (!del_pos_ok) code = STS_BAD_POS;
      end
      KIND_SEARCH, KIND_FREQ: op_class = OPC_SCAN;
      default: op_class = OPC_NONE;
    endcase
  end

  // Status to the controller
  assign st.op_class     = op_class;
  assign st.err          = (code != STS_OK);
  assign st.empty        = empty;
  assign st.ins_no_shift = (count_r == ins_at);
  assign st.up_last      = ((ptr_r - CW'(1)) == ins_at);
  assign st.del_no_shift = ((del_at + CW'(1)) >= count_r);
  assign st.dn_last      = ((ptr_r + CW'(2)) >= count_r);
  assign st.scan_last    = ((ptr_r + CW'(1)) == count_r);

  // Memory address and data selection
  always_comb begin
    unique case (cmd.rd_src)
      RD_PTR_M1: rd_addr = ptr_r - CW'(1);
      RD_PTR_P1: rd_addr = ptr_r + CW'(1);
      default:   rd_addr = ptr_r;
    endcase
    unique case (cmd.wr_src)
      WR_INS: begin
        wr_addr = ins_at;
        wr_data = value_r;
      end
      WR_SET: begin
        wr_addr = pos_idx;
        wr_data = value_r;
      end
      default: begin
        wr_addr = ptr_r;
        wr_data = rdata_r;
      end
    endcase
  end

  // Entry memory: one write, one registered read per cycle
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[wr_addr[AW-1:0]] <= wr_data;
    end
    if (cmd.rd_en) begin
      rdata_r <= mem[rd_addr[AW-1:0]];
    end
  end

  // Item capture, pointer, status and match counter
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      kind_r  <= in_kind;
      value_r <= value_fit;
      pos_r   <= in_position;
    end
    if (cmd.load_ptr) begin
      unique case (cmd.ptr_src)
        PTR_COUNT:  ptr_r <= count_r;
        PTR_DEL_AT: ptr_r <= del_at;
        default:    ptr_r <= '0;
      endcase
    end else if (cmd.ptr_inc) begin
      ptr_r <= ptr_r + CW'(1);
    end else if (cmd.ptr_dec) begin
      ptr_r <= ptr_r - CW'(1);
    end
    if (cmd.save_status) begin
      res_status_r <= code;
      match_r      <= '0;
    end else if (cmp_pend_r && (rdata_r == value_r)) begin
      match_r <= match_r + CW'(1);
    end
  end

  // Control registers: entry count and compare pending flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r    <= '0;
      cmp_pend_r <= 1'b0;
    end else begin
      cmp_pend_r <= cmd.scan_rd;
      if (cmd.cnt_inc)      count_r <= count_r + CW'(1);
      else if (cmd.cnt_dec) count_r <= count_r - CW'(1);
    end
  end

  // Result registers
  assign match_ext = {7'd0, match_r};
  assign count_ext = {7'd0, count_r};

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_status      <= res_status_r;
      out_found       <= (kind_r == KIND_SEARCH) && (match_r != '0);
      out_match_count <= (kind_r == KIND_FREQ) ? match_ext[6:0] : 7'd0;
      out_entry_count <= count_ext[6:0];
    end
  end

  // Checks
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CAP_C) else $error("entry count above capacity");
  a_inc_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.cnt_inc |-> !full) else $error("insert committed while full");
  a_dec_some: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.cnt_dec |-> !empty) else $error("delete committed while empty");

endmodule

`default_nettype wire

// ===== rtl/pls_ctrl.sv =====
// pls_ctrl: sequencing state machine of the positional list engine.
// Drives datapath commands from its status; uses pls_pkg.
`default_nettype none

module pls_ctrl (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  wire                 out_ready,
  input  pls_pkg::pls_stat_t  st,
  output pls_pkg::pls_cmd_t   cmd
);
  import pls_pkg::*;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_DECIDE   = 4'd1;
  localparam logic [3:0] S_UP_RD    = 4'd2;
  localparam logic [3:0] S_UP_WR    = 4'd3;
  localparam logic [3:0] S_PUT      = 4'd4;
  localparam logic [3:0] S_DN_RD    = 4'd5;
  localparam logic [3:0] S_DN_WR    = 4'd6;
  localparam logic [3:0] S_DEL_END  = 4'd7;
  localparam logic [3:0] S_SCAN     = 4'd8;
  localparam logic [3:0] S_SCAN_END = 4'd9;
  localparam logic [3:0] S_DONE     = 4'd10;

  logic [3:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  // Next state and commands
  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        cmd.save_status = 1'b1;
        if (st.err) begin
          state_nxt = S_DONE;
        end else begin
          unique case (st.op_class)
            OPC_INS: begin
              cmd.load_ptr = 1'b1;
              cmd.ptr_src  = PTR_COUNT;
              state_nxt    = st.ins_no_shift ? S_PUT : S_UP_RD;
            end
            OPC_DEL: begin
              cmd.load_ptr = 1'b1;
              cmd.ptr_src  = PTR_DEL_AT;
              state_nxt    = st.del_no_shift ? S_DEL_END : S_DN_RD;
            end
            OPC_SET: begin
              cmd.wr_en  = 1'b1;
              cmd.wr_src = WR_SET;
              state_nxt  = S_DONE;
            end
            OPC_SCAN: begin
              if (st.empty) begin
                state_nxt = S_DONE;
              end else begin
                cmd.load_ptr = 1'b1;
                cmd.ptr_src  = PTR_ZERO;
                state_nxt    = S_SCAN;
              end
            end
            default: state_nxt = S_DONE;
          endcase
        end
      end
      // Open a gap: mem[ptr] <= mem[ptr-1], walking down to the target
      S_UP_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_src = RD_PTR_M1;
        state_nxt  = S_UP_WR;
      end
      S_UP_WR: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_src  = WR_SHIFT;
        cmd.ptr_dec = 1'b1;
        state_nxt   = st.up_last ? S_PUT : S_UP_RD;
      end
      S_PUT: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_src  = WR_INS;
        cmd.cnt_inc = 1'b1;
        state_nxt   = S_DONE;
      end
      // Close a gap: mem[ptr] <= mem[ptr+1], walking up to the end
      S_DN_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_src = RD_PTR_P1;
        state_nxt  = S_DN_WR;
      end
      S_DN_WR: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_src  = WR_SHIFT;
        cmd.ptr_inc = 1'b1;
        state_nxt   = st.dn_last ? S_DEL_END : S_DN_RD;
      end
      S_DEL_END: begin
        cmd.cnt_dec = 1'b1;
        state_nxt   = S_DONE;
      end
      // Stream every entry through the comparator
      S_SCAN: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_src  = RD_PTR;
        cmd.scan_rd = 1'b1;
        cmd.ptr_inc = 1'b1;
        state_nxt   = st.scan_last ? S_SCAN_END : S_SCAN;
      end
      S_SCAN_END: state_nxt = S_DONE;
      // Hand the result to the output register once it is free
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Output valid flag
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out)     out_valid_nxt = 1'b1;
    else if (out_ready)   out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Checks
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready) else $error("item accepted while busy");
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid_r || out_ready)) else $error("pending result overwritten");
  a_one_port_op: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.rd_en && cmd.wr_en)) else $error("read and write in one cycle");
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_DONE)) else $error("result outside done");

endmodule

`default_nettype wire
